FILE: rtl/core/npc_pkg.sv
`default_nettype none
package npc_pkg;

  localparam int PaletteSizeDef = 256;
  localparam int IndexReach     = 256;
  localparam int ColorW         = 8;
  localparam int IdxW           = 8;
  localparam int DistW          = 10;
  localparam int CountW         = 9;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [IdxW-1:0]   best_idx;
    logic [DistW-1:0]  best_dist;
  } item_t;

  function automatic logic [ColorW-1:0] abs_diff(input logic [ColorW-1:0] a,
                                                 input logic [ColorW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/npc_cell.sv
`default_nettype none
module npc_cell import npc_pkg::*; #(
  parameter int CellIdx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire item_t             item_i,
  output item_t                  item_o
);

  logic [ColorW-1:0] ent_r_q, ent_g_q, ent_b_q;
  logic              vld_q;
  item_t             pay_q, pay_d;
  logic [DistW-1:0]  dist_sum;
  logic              is_load, take;

  assign is_load = item_i.vld && (item_i.cmd == CMD_LOAD) && (item_i.idx == IdxW'(CellIdx));

  assign dist_sum = DistW'(abs_diff(ent_r_q, item_i.red))
                  + DistW'(abs_diff(ent_g_q, item_i.green))
                  + DistW'(abs_diff(ent_b_q, item_i.blue));

  always_comb begin
    take  = (CountW'(CellIdx) < count_i) &&
            ((CellIdx == 0) || (dist_sum < item_i.best_dist));
    pay_d = item_i;
    if (take) begin
      pay_d.best_idx  = IdxW'(CellIdx);
      pay_d.best_dist = dist_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= item_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
    if (en_i && is_load) begin
      ent_r_q <= item_i.red;
      ent_g_q <= item_i.green;
      ent_b_q <= item_i.blue;
    end
  end

  always_comb begin
    item_o     = pay_q;
    item_o.vld = vld_q;
  end

endmodule
`default_nettype wire

FILE: rtl/core/nearest_palette_color.sv
// Nearest palette color search, L1 distance.
// Input channel valid_i/stall_o carries cmd_i, entry_index_i, red_i, green_i,
// blue_i. A load item (cmd 0) writes palette slot entry_index_i; slots at or
// beyond the searched range are still loadable up to the cell count.
// A query item (cmd 1) returns palette_index_o and distance_o on valid_o/stall_i.
// Ties go to the lowest index. cfg_we_i/cfg_wdata_i set entries_in_use
// (0 acts as 1, values above the cell count clamp to it).
// The block is a systolic chain of min(PALETTE_SIZE,256) cells, one per
// palette entry, each holding its entry and one register stage.
// Each item passes through the register stage of every cell in turn, and a
// query result shows on valid_o from the register of the last cell.
// Throughput: one item per cycle unless stalled. Loads travel the chain too,
// so order against queries is kept.
// Reset clears all valid bits and sets entries_in_use to the cell count;
// palette contents are undefined until loaded.
// When stall_i holds a result, the whole chain freezes and stall_o is raised;
// nothing is lost or repeated.
`default_nettype none
module nearest_palette_color import npc_pkg::*; #(
  parameter int PALETTE_SIZE = PaletteSizeDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic              cmd_i,
  input  wire logic [IdxW-1:0]   entry_index_i,
  input  wire logic [ColorW-1:0] red_i,
  input  wire logic [ColorW-1:0] green_i,
  input  wire logic [ColorW-1:0] blue_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic [IdxW-1:0]        palette_index_o,
  output logic [DistW-1:0]       distance_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i
);

  localparam int NCell = (PALETTE_SIZE < IndexReach) ? PALETTE_SIZE : IndexReach;

  logic [CountW-1:0] count_q, count_d;
  logic              en;
  item_t             head;
  item_t             chain [NCell+1];
  item_t             last;

  always_comb begin
    count_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      count_d = CountW'(1);
    end else if (cfg_wdata_i > CountW'(NCell)) begin
      count_d = CountW'(NCell);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(NCell);
    end else if (cfg_we_i) begin
      count_q <= count_d;
    end
  end

  assign last    = chain[NCell];
  assign valid_o = last.vld && (last.cmd == CMD_QUERY);
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  always_comb begin
    head       = '0;
    head.vld   = valid_i;
    head.cmd   = cmd_i;
    head.idx   = entry_index_i;
    head.red   = red_i;
    head.green = green_i;
    head.blue  = blue_i;
  end

  assign chain[0] = head;

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    npc_cell #(.CellIdx(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .count_i(count_q),
      .item_i (chain[k]),
      .item_o (chain[k+1])
    );
  end

  assign palette_index_o = last.best_idx;
  assign distance_o      = last.best_dist;

`ifndef SYNTH
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> distance_o <= DistW'(765))
    else $error("distance out of range");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> CountW'(palette_index_o) < count_q)
    else $error("index outside searched range");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CountW'(NCell))
    else $error("search count not saturated");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("result dropped during stall");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
  import npc_pkg::*;

  localparam int ChainDepth = 256;
  localparam int DrainWait  = ChainDepth + 40;
  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 800;

  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] dist_val;
  } nearest_t;

  logic              clk_i;
  logic              rst_ni;
  logic              valid_i;
  logic              stall_o;
  logic              cmd_i;
  logic [IdxW-1:0]   entry_index_i;
  logic [ColorW-1:0] red_i;
  logic [ColorW-1:0] green_i;
  logic [ColorW-1:0] blue_i;
  logic              valid_o;
  logic              stall_i;
  logic [IdxW-1:0]   palette_index_o;
  logic [DistW-1:0]  distance_o;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  logic [23:0] pal_model [ChainDepth];
  int          search_n;
  nearest_t    nearest_q[$];
  int          err_cnt;
  int          items_in;
  int          results_out;
  bit          idle_en;
  int          hold_cnt;

  nearest_palette_color dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .palette_index_o(palette_index_o),
    .distance_o     (distance_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int adiff(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic nearest_t find_nearest(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    nearest_t res;
    int       best;
    int       d;
    best = 1024;
    res.idx = '0;
    res.dist_val = '0;
    for (int i = 0; i < search_n; i++) begin
      d = adiff(pal_model[i][23:16], r) + adiff(pal_model[i][15:8], g) +
          adiff(pal_model[i][7:0], b);
      if (d < best) begin
        best = d;
        res.idx = i[IdxW-1:0];
        res.dist_val = d[DistW-1:0];
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    if (!idle_en) return 0;
    if ($urandom_range(0, 31) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    @(negedge clk_i);
    while (stall_o) @(negedge clk_i);
    @(posedge clk_i);
    items_in++;
    if (cmd == CMD_LOAD) pal_model[idx] = {r, g, b};
    else nearest_q.push_back(find_nearest(r, g, b));
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_count(input int v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CountW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    search_n = (v == 0) ? 1 : (v > ChainDepth) ? ChainDepth : v;
  endtask

  task automatic send_random(input bit coarse);
    logic [7:0] c [3];
    for (int k = 0; k < 3; k++) begin
      if (coarse) c[k] = 8'($urandom_range(0, 4) * 63);
      else c[k] = 8'($urandom);
    end
    send_item(($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_QUERY, 8'($urandom),
              c[0], c[1], c[2]);
  endtask

  task automatic test_load_palette();
    for (int i = 0; i < ChainDepth; i++)
      send_item(CMD_LOAD, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    set_count(4);
    send_item(CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(CMD_LOAD, 8'd1, 8'hff, 8'hff, 8'hff);
    send_item(CMD_LOAD, 8'd2, 8'h80, 8'h40, 8'h20);
    send_item(CMD_LOAD, 8'd3, 8'h80, 8'h40, 8'h20);
    send_item(CMD_QUERY, 8'hff, 8'h00, 8'h00, 8'h00);
    send_item(CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    send_item(CMD_QUERY, 8'h55, 8'h80, 8'h40, 8'h20);
    send_item(CMD_QUERY, 8'haa, 8'h80, 8'h7f, 8'h7f);
    send_item(CMD_QUERY, 8'h00, 8'h81, 8'h41, 8'h1f);
    // near-tie between the two extremes; slot 3 is still the nearest
    send_item(CMD_LOAD, 8'd2, 8'h00, 8'h00, 8'h00);
    send_item(CMD_QUERY, 8'h00, 8'h80, 8'h80, 8'h7f);
    send_item(CMD_LOAD, 8'd255, 8'h12, 8'h34, 8'h56);
    send_item(CMD_QUERY, 8'h00, 8'h12, 8'h34, 8'h56);
    set_count(1);
    send_item(CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    send_item(CMD_QUERY, 8'hff, 8'h00, 8'h00, 8'h00);
    set_count(0);
    send_item(CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    set_count(256);
    send_item(CMD_QUERY, 8'h00, 8'h12, 8'h34, 8'h56);
    set_count(511);
    send_item(CMD_QUERY, 8'h00, 8'h12, 8'h34, 8'h56);
    set_count(257);
    send_item(CMD_QUERY, 8'h00, 8'hfe, 8'h01, 8'h7f);
  endtask

  task automatic test_random_counts();
    int counts [6] = '{1, 2, 17, 128, 255, 256};
    for (int p = 0; p < 6; p++) begin
      set_count(counts[p]);
      repeat (150) send_random(p[0]);
    end
    set_count($urandom_range(1, 511));
    repeat (100) send_random(1'b0);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (150) send_random(1'b1);
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    valid_i <= 1'b0;
    @(negedge clk_i);
    hold_cnt = HoldCycles;
    @(posedge clk_i);
    repeat (250) send_item(CMD_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      stall_i  <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!idle_en) begin
      stall_i <= 1'b0;
    end else if ($urandom_range(0, 63) == 0) begin
      stall_i  <= 1'b1;
      hold_cnt <= $urandom_range(10, 50);
    end else begin
      stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(negedge clk_i) begin
    nearest_t e;
    if (rst_ni && valid_o && !stall_i) begin
      results_out++;
      if (nearest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result idx=%0d dist=%0d",
                                    palette_index_o, distance_o);
      end else begin
        e = nearest_q.pop_front();
        if (palette_index_o !== e.idx || distance_o !== e.dist_val) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected idx=%0d dist=%0d, got idx=%0d dist=%0d",
                     e.idx, e.dist_val, palette_index_o, distance_o);
        end
      end
    end
  end

  initial begin
    int idle;
    int last;
    idle = 0;
    last = 0;
    forever begin
      @(posedge clk_i);
      if (items_in + results_out != last) begin
        last = items_in + results_out;
        idle = 0;
      end else if (++idle >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    cmd_i         = CMD_LOAD;
    entry_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    stall_i       = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    err_cnt       = 0;
    items_in      = 0;
    results_out   = 0;
    idle_en       = 1'b1;
    hold_cnt      = 0;
    search_n      = ChainDepth;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_palette();
    test_directed();
    test_random_counts();
    test_no_idle();
    test_backpressure();
    drain();
    if (err_cnt == 0 && nearest_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/npc_pkg.sv
rtl/core/npc_cell.sv
rtl/core/nearest_palette_color.sv
tb/sv/testbench.sv
